@@ rtl/core/uhb_pkg.sv @@
// Shared types and constants for the undo history budget block.
// No dependencies; imported by undo_history_budget_core and uhb_checker.
`default_nettype none

package uhb_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_SIZE_WIDTH = 32;

    localparam int STEPS_W  = 7;
    localparam int CFG_W    = 32;
    localparam int FIELD_W  = 32;
    localparam int PADDR_W  = 4;
    localparam int REGIDX_W = 2;

    localparam logic [STEPS_W-1:0] RST_STEP_LIMIT   = 7'd64;
    localparam logic [CFG_W-1:0]   RST_BYTE_BUDGET  = 32'd16777216;
    localparam logic [CFG_W-1:0]   RST_RECORD_LIMIT = 32'd1048576;

    typedef enum logic [REGIDX_W-1:0] {
        REG_STEP_LIMIT   = 2'd0,
        REG_BYTE_BUDGET  = 2'd1,
        REG_RECORD_LIMIT = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_UNDO = 2'd1,
        KIND_REDO = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_REJECT = 2'd1,
        STAT_EMPTY  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_DECODE = 2'd1,
        S_REDO   = 2'd2,
        S_EVICT  = 2'd3
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/undo_history_budget_core.sv @@
// Bounded undo/redo history of record sizes: ring memory, cursor, byte total.
// Depends on uhb_pkg; one sequencer drives a shared subtract/compare datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  in      | sink      | in_valid / in_stall     | kind, record_bytes
//  out     | source    | out_valid / out_stall   | status, record_slot, dropped_count,
//          |           |                         | undo_depth, redo_depth, bytes_held
//  cfg     | APB slave | psel/penable/pready     | paddr, pwdata, prdata
//
// Undo, redo, unused kinds and out-of-bounds pushes load their result from S_DECODE.
// Other pushes drop the redo branch in S_REDO, then evict oldest records in S_EVICT, one
// ring read per cycle, until the push fits or is rejected; results load only when out_free.
// in_stall is high from accept until the result loads; only then is a new item accepted.
// Reset clears the history and loads the register defaults; the ring needs no clear.
// A new item is accepted while a result waits on out_stall; its result holds until free.
`default_nettype none

module undo_history_budget_core
    import uhb_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int SIZE_WIDTH = DEF_SIZE_WIDTH,
    localparam int SLOT_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           kind,
    input  wire logic [FIELD_W-1:0]   record_bytes,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                status,
    output logic [SLOT_W-1:0]         record_slot,
    output logic [CNT_W-1:0]          dropped_count,
    output logic [CNT_W-1:0]          undo_depth,
    output logic [CNT_W-1:0]          redo_depth,
    output logic [FIELD_W-1:0]        bytes_held,

    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [CFG_W-1:0]     pwdata,
    output logic [CFG_W-1:0]          prdata,
    output logic                      pready
);

    localparam int SW = SIZE_WIDTH;
    localparam int BW = (SW > CFG_W) ? SW : CFG_W;
    localparam int KW = (CNT_W > STEPS_W) ? CNT_W : STEPS_W;
    localparam logic [KW-1:0]     CAP_K    = KW'(CAPACITY);
    localparam logic [CNT_W:0]    CAP_S    = (CNT_W + 1)'(CAPACITY);
    localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(CAPACITY - 1);

    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  ofs);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(ofs);
        if (s >= CAP_S)
        begin
            s = s - CAP_S;
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] x);
        return (x == SLOT_TOP) ? '0 : x + SLOT_W'(1);
    endfunction

    // configuration registers
    logic [STEPS_W-1:0] step_limit_reg;
    logic [CFG_W-1:0]   byte_budget_reg;
    logic [CFG_W-1:0]   record_limit_reg;
    logic [REGIDX_W-1:0] cfg_idx;
    logic                cfg_we;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[PADDR_W-1:2];
    assign cfg_we  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg   <= RST_STEP_LIMIT;
            byte_budget_reg  <= RST_BYTE_BUDGET;
            record_limit_reg <= RST_RECORD_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_STEP_LIMIT:   step_limit_reg   <= pwdata[STEPS_W-1:0];
                REG_BYTE_BUDGET:  byte_budget_reg  <= pwdata;
                REG_RECORD_LIMIT: record_limit_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_STEP_LIMIT:   prdata = CFG_W'(step_limit_reg);
            REG_BYTE_BUDGET:  prdata = byte_budget_reg;
            REG_RECORD_LIMIT: prdata = record_limit_reg;
            default:          prdata = '0;
        endcase
    end

    // ring memory
    logic [SW-1:0]     ring_mem [CAPACITY];
    logic [SW-1:0]     rd_data_reg;
    logic [SLOT_W-1:0] rd_addr;
    logic              ring_we;

    // sequencer and history state
    state_t            state_reg, state_next;
    logic [1:0]        kind_reg;
    logic [SW-1:0]     rb_reg;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [CNT_W-1:0]  entry_reg, entry_next;
    logic [CNT_W-1:0]  cursor_reg, cursor_next;
    logic [SW-1:0]     total_reg, total_next;
    logic [SW-1:0]     kept_reg, kept_next;
    logic [BW-1:0]     limit_reg, limit_next;
    logic [SLOT_W-1:0] rptr_reg, rptr_next;
    logic [SLOT_W-1:0] push_slot_reg, push_slot_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  drop_reg, drop_next;
    logic [CNT_W-1:0]  kcount_reg, kcount_next;
    logic              pend_reg, pend_next;

    // output register
    logic              out_valid_reg;
    status_t           out_status_reg, out_status_next;
    logic [SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic [CNT_W-1:0]  out_drop_reg, out_drop_next;
    logic [CNT_W-1:0]  out_undo_reg, out_undo_next;
    logic [CNT_W-1:0]  out_redo_reg, out_redo_next;
    logic [FIELD_W-1:0] out_bytes_reg, out_bytes_next;
    logic              out_load;
    logic              out_free;

    logic              accept;
    logic [BW-1:0]     rb_in_w;
    logic [BW-1:0]     rb_w;
    logic              push_bad;
    logic              need_evict;
    logic [SW-1:0]     commit_total;
    logic [CNT_W:0]    oldest_sum;
    logic [BW-1:0]     total_w;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid & ~in_stall;
    assign out_free = ~out_valid_reg | ~out_stall;
    assign rb_in_w  = BW'(record_bytes);
    assign rb_w     = BW'(rb_reg);

    assign push_bad = (KW'(step_limit_reg) > CAP_K) || (rb_reg == '0)
                   || (rb_w > BW'(record_limit_reg)) || (rb_w > BW'(byte_budget_reg));
    assign need_evict = (KW'(kcount_reg) >= KW'(step_limit_reg)) || (BW'(kept_reg) > limit_reg);
    assign commit_total = kept_reg + rb_reg;
    assign oldest_sum   = (CNT_W + 1)'(oldest_reg) + (CNT_W + 1)'(drop_reg);

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[push_slot_reg] <= rb_reg;
        end
        rd_data_reg <= ring_mem[rd_addr];
    end

    always_comb
    begin
        state_next      = state_reg;
        oldest_next     = oldest_reg;
        entry_next      = entry_reg;
        cursor_next     = cursor_reg;
        total_next      = total_reg;
        kept_next       = kept_reg;
        limit_next      = limit_reg;
        rptr_next       = rptr_reg;
        push_slot_next  = push_slot_reg;
        rem_next        = rem_reg;
        drop_next       = drop_reg;
        kcount_next     = kcount_reg;
        pend_next       = pend_reg;
        rd_addr         = rptr_reg;
        ring_we         = 1'b0;
        out_load        = 1'b0;
        out_status_next = STAT_REJECT;
        out_slot_next   = '0;
        out_drop_next   = '0;
        out_undo_next   = cursor_reg;
        out_redo_next   = entry_reg - cursor_reg;
        total_w         = BW'(total_reg);
        out_bytes_next  = total_w[FIELD_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (kind_reg)
                    KIND_PUSH:
                    begin
                        if (push_bad)
                        begin
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            kept_next      = total_reg;
                            limit_next     = BW'(byte_budget_reg) - rb_w;
                            rptr_next      = slot_of(oldest_reg, cursor_reg);
                            push_slot_next = slot_of(oldest_reg, cursor_reg);
                            rem_next       = entry_reg - cursor_reg;
                            drop_next      = '0;
                            kcount_next    = cursor_reg;
                            pend_next      = 1'b0;
                            state_next     = S_REDO;
                        end
                    end
                    KIND_UNDO:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (cursor_reg == '0)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cursor_next     = cursor_reg - CNT_W'(1);
                                out_status_next = STAT_OK;
                                out_slot_next   = slot_of(oldest_reg, cursor_reg - CNT_W'(1));
                                out_undo_next   = cursor_reg - CNT_W'(1);
                                out_redo_next   = entry_reg - cursor_reg + CNT_W'(1);
                            end
                        end
                    end
                    KIND_REDO:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (cursor_reg >= entry_reg)
                            begin
                                out_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                cursor_next     = cursor_reg + CNT_W'(1);
                                out_status_next = STAT_OK;
                                out_slot_next   = slot_of(oldest_reg, cursor_reg);
                                out_undo_next   = cursor_reg + CNT_W'(1);
                                out_redo_next   = entry_reg - cursor_reg - CNT_W'(1);
                            end
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end

            S_REDO:
            begin
                if (pend_reg)
                begin
                    kept_next = kept_reg - rd_data_reg;
                end
                if (rem_reg != '0)
                begin
                    rd_addr   = rptr_reg;
                    rptr_next = slot_inc(rptr_reg);
                    rem_next  = rem_reg - CNT_W'(1);
                    pend_next = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    rd_addr    = oldest_reg;
                    rptr_next  = slot_inc(oldest_reg);
                    state_next = S_EVICT;
                end
            end

            S_EVICT:
            begin
                if (!need_evict)
                begin
                    if (out_free)
                    begin
                        ring_we         = 1'b1;
                        oldest_next     = (oldest_sum >= CAP_S) ? SLOT_W'(oldest_sum - CAP_S)
                                                                : SLOT_W'(oldest_sum);
                        entry_next      = kcount_reg + CNT_W'(1);
                        cursor_next     = kcount_reg + CNT_W'(1);
                        total_next      = commit_total;
                        out_load        = 1'b1;
                        out_status_next = STAT_OK;
                        out_slot_next   = push_slot_reg;
                        out_drop_next   = drop_reg;
                        out_undo_next   = kcount_reg + CNT_W'(1);
                        out_redo_next   = '0;
                        total_w         = BW'(commit_total);
                        out_bytes_next  = total_w[FIELD_W-1:0];
                        state_next      = S_IDLE;
                    end
                end
                else if (drop_reg >= cursor_reg)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    kept_next   = kept_reg - rd_data_reg;
                    drop_next   = drop_reg + CNT_W'(1);
                    kcount_next = kcount_reg - CNT_W'(1);
                    rd_addr     = rptr_reg;
                    rptr_next   = slot_inc(rptr_reg);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            oldest_reg    <= '0;
            entry_reg     <= '0;
            cursor_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oldest_reg <= oldest_next;
            entry_reg  <= entry_next;
            cursor_reg <= cursor_next;
            total_reg  <= total_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            rb_reg   <= rb_in_w[SW-1:0];
        end
        kept_reg      <= kept_next;
        limit_reg     <= limit_next;
        rptr_reg      <= rptr_next;
        push_slot_reg <= push_slot_next;
        rem_reg       <= rem_next;
        drop_reg      <= drop_next;
        kcount_reg    <= kcount_next;
        pend_reg      <= pend_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_slot_reg   <= out_slot_next;
            out_drop_reg   <= out_drop_next;
            out_undo_reg   <= out_undo_next;
            out_redo_reg   <= out_redo_next;
            out_bytes_reg  <= out_bytes_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign record_slot   = out_slot_reg;
    assign dropped_count = out_drop_reg;
    assign undo_depth    = out_undo_reg;
    assign redo_depth    = out_redo_reg;
    assign bytes_held    = out_bytes_reg;

endmodule

`default_nettype wire

@@ rtl/core/uhb_checker.sv @@
// Port-level checks for undo_history_budget_core, bound into that module.
// Depends on uhb_pkg for the status codes, FIELD_W and DEF_CAPACITY.
`default_nettype none

module uhb_checker
    import uhb_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int SLOT_W = $clog2(CAPACITY),
    localparam int CNT_W  = $clog2(CAPACITY + 1)
)
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         status,
    input wire logic [SLOT_W-1:0]  record_slot,
    input wire logic [CNT_W-1:0]   dropped_count,
    input wire logic [CNT_W-1:0]   undo_depth,
    input wire logic [CNT_W-1:0]   redo_depth,
    input wire logic [FIELD_W-1:0] bytes_held
);

    localparam logic [CNT_W:0] CAP_S = (CNT_W + 1)'(CAPACITY);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(record_slot)
            && $stable(dropped_count) && $stable(undo_depth) && $stable(redo_depth)
            && $stable(bytes_held))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in work");

    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_REJECT || status == STAT_EMPTY)
            |-> record_slot == '0 && dropped_count == '0)
        else $error("failed step reports a slot or evictions");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((CNT_W + 1)'(undo_depth) + (CNT_W + 1)'(redo_depth)) <= CAP_S)
        else $error("history depth exceeds capacity");

    a_push_ok_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_OK && dropped_count != '0
            |-> redo_depth == '0 && undo_depth != '0)
        else $error("evicting push left a redo branch");

endmodule

bind undo_history_budget_core uhb_checker #(.CAPACITY(CAPACITY)) u_uhb_checker (.*);

`default_nettype wire
